[sv/fir_convolve_mirror_boundary_top_macros.svh]
// Assertion macros shared by the mirrored-boundary FIR block.
`ifndef FIR_CONVOLVE_MIRROR_BOUNDARY_TOP_MACROS_SVH
`define FIR_CONVOLVE_MIRROR_BOUNDARY_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FCMB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcmb: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define FCMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcmb: next-cycle check failed");

// Condition never holds.
`define FCMB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fcmb: forbidden condition seen");

`endif

[sv/fcmb_pkg.sv]
// Shared constants, FSM state type and controller/datapath handshake structs.
`timescale 1ns / 1ps

package fcmb_pkg;

    localparam int COEF_WIDTH      = 18;
    localparam int FRAC_SHIFT      = 16;
    localparam int TAP_INDEX_WIDTH = 5;
    localparam int HALF_TAPS_WIDTH = 4;
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;
    localparam int REG_IDX_WIDTH   = APB_ADDR_WIDTH - 2;

    localparam logic [HALF_TAPS_WIDTH-1:0] HALF_TAPS_RESET   = 4'd1;
    localparam logic [REG_IDX_WIDTH-1:0]   REG_IDX_HALF_TAPS = '0;

    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT,
        ST_SHORT
    } state_t;

    typedef struct packed {
        logic accept;
        logic loop_init;
        logic out_next;
        logic tap_start;
        logic tap_issue;
        logic emit;
        logic emit_short;
        logic seq_clear;
    } cmd_t;

    typedef struct packed {
        logic is_sample;
        logic is_last;
        logic has_out;
        logic short_seq;
        logic tap_last;
        logic pipe_busy;
        logic out_free;
        logic at_vj;
        logic short_final;
    } status_t;

endpackage

[sv/fir_convolve_mirror_boundary_top.sv]
// Odd-length FIR over a sample sequence with mirrored ends, with an APB register port.
//
// Input channel (s_*): a word with s_kind = 0 loads tap s_tap_index with s_coef_value
// (Q2.16); s_kind = 1 delivers one Q1.15 sample, s_last closing the sequence.
// Result channel (m_*): filtered Q1.15 values, rounded and saturated, with flags
// saturated, too_short (sequence not longer than h) and final_res (last of sequence).
// APB register 0 (byte address 0): half_taps h, kernel of 2h+1 taps, reset 1.
// Steps: a coefficient word or a sample that gives no result goes from idle through
// the decide state back to idle. A sample that gives one result runs one tap per cycle
// through the single shared multiply-accumulate, then drains the store read, multiply
// and accumulate stages, then loads the result register.
// The last sample flushes h+1 results; a too-short sequence gives one zero result
// per sample, one per cycle while the output register is free.
// While a result waits in the output register the block still takes the next word;
// when m_ready stays low it holds at the point of loading the next result.
// Reset clears the write pointer, the sample count and the handshake state; taps are
// unknown until written. No clearing pass is run.
`timescale 1ns / 1ps
`include "fir_convolve_mirror_boundary_top_macros.svh"

module fir_convolve_mirror_boundary_top #(
    parameter int MAX_HALF     = 15,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // APB register port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [fcmb_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [fcmb_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [fcmb_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                    pready,
    // input words
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_kind,
    input  logic [fcmb_pkg::TAP_INDEX_WIDTH-1:0]    s_tap_index,
    input  logic signed [fcmb_pkg::COEF_WIDTH-1:0]  s_coef_value,
    input  logic signed [SAMPLE_WIDTH-1:0]          s_sample,
    input  logic                                    s_last,
    // result words
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]          m_value,
    output logic                                    m_saturated,
    output logic                                    m_too_short,
    output logic                                    m_final_res
);

    localparam int HW = $clog2(MAX_HALF + 1);
    localparam int DW = fcmb_pkg::APB_DATA_WIDTH;

    logic [fcmb_pkg::HALF_TAPS_WIDTH-1:0] half_taps_reg, half_taps_next;
    logic                                 reg_hit;
    logic [HW-1:0]                        h_eff;
    fcmb_pkg::cmd_t                       cmd;
    fcmb_pkg::status_t                    stat;

    assign reg_hit = paddr[fcmb_pkg::APB_ADDR_WIDTH-1:2] == fcmb_pkg::REG_IDX_HALF_TAPS;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? DW'(half_taps_reg) : '0;

    always_comb begin
        half_taps_next = half_taps_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            half_taps_next = pwdata[fcmb_pkg::HALF_TAPS_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_taps_reg <= fcmb_pkg::HALF_TAPS_RESET;
        end else begin
            half_taps_reg <= half_taps_next;
        end
    end

    // clip h to the window the stores can hold
    always_comb begin
        if (32'(half_taps_reg) > 32'(MAX_HALF)) begin
            h_eff = HW'(MAX_HALF);
        end else begin
            h_eff = HW'(half_taps_reg);
        end
    end

    fcmb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fcmb_datapath #(
        .MAX_HALF     (MAX_HALF),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .h_eff        (h_eff),
        .s_kind       (s_kind),
        .s_tap_index  (s_tap_index),
        .s_coef_value (s_coef_value),
        .s_sample     (s_sample),
        .s_last       (s_last),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_value      (m_value),
        .m_saturated  (m_saturated),
        .m_too_short  (m_too_short),
        .m_final_res  (m_final_res)
    );

    // a result is loaded only into a free or draining output register
    `FCMB_ASSERT_IMPL(a_load_when_free, aclk, aresetn, cmd.emit || cmd.emit_short, !m_valid || m_ready)
    // a new word is taken only with the MAC pipeline empty
    `FCMB_ASSERT_IMPL(a_ready_pipe_empty, aclk, aresetn, s_ready, !stat.pipe_busy)
    // one word at a time
    `FCMB_ASSERT_NEXT(a_accept_blocks, aclk, aresetn, s_valid && s_ready, !s_ready)
    `FCMB_ASSERT_NEVER(a_single_load, aclk, aresetn, cmd.emit && cmd.emit_short)

endmodule

[sv/fcmb_ctrl.sv]
// Sequencer: accepts words, steps the tap loop and the output loop of the datapath.
`timescale 1ns / 1ps

module fcmb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fcmb_pkg::status_t stat,
    output fcmb_pkg::cmd_t    cmd
);

    fcmb_pkg::state_t state_reg;
    fcmb_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcmb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fcmb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = fcmb_pkg::ST_DECIDE;
                end
            end
            fcmb_pkg::ST_DECIDE: begin
                if (!stat.is_sample) begin
                    state_next = fcmb_pkg::ST_IDLE;
                end else if (!stat.is_last) begin
                    state_next = stat.has_out ? fcmb_pkg::ST_ISSUE : fcmb_pkg::ST_IDLE;
                end else begin
                    state_next = stat.short_seq ? fcmb_pkg::ST_SHORT : fcmb_pkg::ST_ISSUE;
                end
            end
            fcmb_pkg::ST_ISSUE: begin
                if (stat.tap_last) begin
                    state_next = fcmb_pkg::ST_DRAIN;
                end
            end
            fcmb_pkg::ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = fcmb_pkg::ST_EMIT;
                end
            end
            fcmb_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = (stat.is_last && !stat.at_vj) ? fcmb_pkg::ST_ISSUE
                                                               : fcmb_pkg::ST_IDLE;
                end
            end
            fcmb_pkg::ST_SHORT: begin
                if (stat.out_free && stat.short_final) begin
                    state_next = fcmb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fcmb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            fcmb_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            fcmb_pkg::ST_DECIDE: begin
                if (stat.is_sample && (stat.is_last || stat.has_out)) begin
                    cmd.loop_init = 1'b1;
                    cmd.tap_start = !(stat.is_last && stat.short_seq);
                end
            end
            fcmb_pkg::ST_ISSUE: begin
                cmd.tap_issue = 1'b1;
            end
            fcmb_pkg::ST_DRAIN: begin
                cmd = '0;
            end
            fcmb_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.is_last && !stat.at_vj) begin
                        // more flush outputs: advance and rerun the tap loop
                        cmd.out_next  = 1'b1;
                        cmd.tap_start = 1'b1;
                    end else if (stat.is_last) begin
                        cmd.seq_clear = 1'b1;
                    end
                end
            end
            fcmb_pkg::ST_SHORT: begin
                if (stat.out_free) begin
                    cmd.emit_short = 1'b1;
                    cmd.seq_clear  = stat.short_final;
                    cmd.out_next   = !stat.short_final;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/fcmb_datapath.sv]
// Sample and tap stores, mirrored index unit, shared MAC pipeline and result register.
`timescale 1ns / 1ps

module fcmb_datapath #(
    parameter int MAX_HALF     = 15,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  fcmb_pkg::cmd_t                              cmd,
    output fcmb_pkg::status_t                           stat,
    input  logic [$clog2(MAX_HALF+1)-1:0]               h_eff,
    input  logic                                        s_kind,
    input  logic [fcmb_pkg::TAP_INDEX_WIDTH-1:0]        s_tap_index,
    input  logic signed [fcmb_pkg::COEF_WIDTH-1:0]      s_coef_value,
    input  logic signed [SAMPLE_WIDTH-1:0]              s_sample,
    input  logic                                        s_last,
    input  logic                                        m_ready,
    output logic                                        m_valid,
    output logic signed [SAMPLE_WIDTH-1:0]              m_value,
    output logic                                        m_saturated,
    output logic                                        m_too_short,
    output logic                                        m_final_res
);

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = AW + 2;
    localparam int PW    = SAMPLE_WIDTH + fcmb_pkg::COEF_WIDTH;
    localparam int ACW   = PW + AW;
    localparam int RW    = ACW - fcmb_pkg::FRAC_SHIFT;
    localparam logic signed [ACW-1:0] ROUND_BIAS = ACW'(2 ** (fcmb_pkg::FRAC_SHIFT - 1));

    // stores
    logic signed [SAMPLE_WIDTH-1:0]         win_mem  [DEPTH];
    logic signed [fcmb_pkg::COEF_WIDTH-1:0] coef_mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0]         win_q_reg;
    logic signed [fcmb_pkg::COEF_WIDTH-1:0] coef_q_reg;

    // sequence state
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic          kind_reg, kind_next;
    logic          last_reg, last_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] k_reg, k_next;

    // MAC pipeline
    logic                  v1_reg, v1_next;
    logic                  v2_reg, v2_next;
    logic                  v3_reg, v3_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         tap_reg, tap_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [ACW-1:0] acc_reg, acc_next;

    // result register
    logic                           m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg, value_next;
    logic                           sat_reg, sat_next;
    logic                           short_reg, short_next;
    logic                           fin_reg, fin_next;

    // derived values
    logic [CW-1:0]         span;
    logic [CW-1:0]         vj_w;
    logic [AW-1:0]         vj;
    logic signed [IW-1:0]  idx_s;
    logic signed [IW-1:0]  vj_s;
    logic [AW-1:0]         age;
    logic [AW:0]           pos_w;
    logic [AW-1:0]         rd_pos;
    logic                  coef_in_range;
    logic [AW-1:0]         coef_addr;
    logic signed [ACW-1:0] rsum;
    logic signed [RW-1:0]  rq;
    logic                  ovf;
    logic signed [SAMPLE_WIDTH-1:0] rvalue;

    assign span = CW'({h_eff, 1'b1});
    assign vj_w = ((seen_reg < span) ? seen_reg : span) - CW'(1);
    assign vj   = vj_w[AW-1:0];
    assign vj_s = $signed(IW'(vj));

    // mirror the tap position about both ends of the sequence
    always_comb begin
        idx_s = $signed(IW'(i_reg)) + $signed(IW'(k_reg)) - $signed(IW'(h_eff));
        if (idx_s < 0) begin
            idx_s = -idx_s;
        end
        if (idx_s > vj_s) begin
            idx_s = vj_s + vj_s - idx_s;
        end
        if (idx_s < 0) begin
            idx_s = '0;
        end
        if (idx_s > vj_s) begin
            idx_s = vj_s;
        end
    end

    // window slot of the mirrored sample, counted back from the newest word
    always_comb begin
        age   = vj - idx_reg;
        pos_w = (AW+1)'(wp_reg) + (AW+1)'(DEPTH - 1) - (AW+1)'(age);
        if (pos_w >= (AW+1)'(DEPTH)) begin
            pos_w = pos_w - (AW+1)'(DEPTH);
        end
        rd_pos = pos_w[AW-1:0];
    end

    assign coef_in_range = 32'(s_tap_index) < 32'(DEPTH);
    assign coef_addr     = AW'(s_tap_index);

    // round half up and saturate
    always_comb begin
        rsum = acc_reg + ROUND_BIAS;
        rq   = rsum[ACW-1:fcmb_pkg::FRAC_SHIFT];
        ovf  = !((&rq[RW-1:SAMPLE_WIDTH-1]) || !(|rq[RW-1:SAMPLE_WIDTH-1]));
        if (ovf) begin
            rvalue = rq[RW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                              : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else begin
            rvalue = rq[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_kind == fcmb_pkg::KIND_SAMPLE) begin
            win_mem[wp_reg] <= s_sample;
        end
        if (cmd.accept && s_kind == fcmb_pkg::KIND_COEF && coef_in_range) begin
            coef_mem[coef_addr] <= s_coef_value;
        end
        win_q_reg  <= win_mem[rd_pos];
        coef_q_reg <= coef_mem[tap_reg];
    end

    always_comb begin
        wp_next      = wp_reg;
        seen_next    = seen_reg;
        kind_next    = kind_reg;
        last_next    = last_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        v1_next      = cmd.tap_issue;
        v2_next      = v1_reg;
        v3_next      = v2_reg;
        idx_next     = idx_reg;
        tap_next     = tap_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        value_next   = value_reg;
        sat_next     = sat_reg;
        short_next   = short_reg;
        fin_next     = fin_reg;

        if (cmd.accept) begin
            kind_next = s_kind;
            last_next = s_last;
            if (s_kind == fcmb_pkg::KIND_SAMPLE) begin
                wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (seen_reg < CW'(DEPTH)) begin
                    seen_next = seen_reg + CW'(1);
                end
            end
        end
        if (cmd.seq_clear) begin
            wp_next   = '0;
            seen_next = '0;
        end
        if (cmd.loop_init) begin
            i_next = (last_reg && stat.short_seq) ? '0 : vj - AW'(h_eff);
        end
        if (cmd.out_next) begin
            i_next = i_reg + AW'(1);
        end
        if (cmd.tap_start) begin
            k_next   = '0;
            acc_next = '0;
        end
        if (cmd.tap_issue) begin
            idx_next = idx_s[AW-1:0];
            tap_next = k_reg;
            k_next   = k_reg + AW'(1);
        end
        if (v2_reg) begin
            prod_next = win_q_reg * coef_q_reg;
        end
        if (v3_reg) begin
            acc_next = acc_reg + ACW'(prod_reg);
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            value_next   = rvalue;
            sat_next     = ovf;
            short_next   = 1'b0;
            fin_next     = last_reg && stat.at_vj;
        end
        if (cmd.emit_short) begin
            m_valid_next = 1'b1;
            value_next   = '0;
            sat_next     = 1'b0;
            short_next   = 1'b1;
            fin_next     = stat.short_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            seen_reg    <= '0;
            kind_reg    <= fcmb_pkg::KIND_COEF;
            last_reg    <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            seen_reg    <= seen_next;
            kind_reg    <= kind_next;
            last_reg    <= last_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        k_reg     <= k_next;
        idx_reg   <= idx_next;
        tap_reg   <= tap_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        value_reg <= value_next;
        sat_reg   <= sat_next;
        short_reg <= short_next;
        fin_reg   <= fin_next;
    end

    always_comb begin
        stat.is_sample   = kind_reg == fcmb_pkg::KIND_SAMPLE;
        stat.is_last     = last_reg;
        stat.has_out     = vj >= AW'(h_eff);
        stat.short_seq   = seen_reg <= CW'(h_eff);
        stat.tap_last    = k_reg == AW'({h_eff, 1'b0});
        stat.pipe_busy   = v1_reg || v2_reg || v3_reg;
        stat.out_free    = !m_valid_reg || m_ready;
        stat.at_vj       = i_reg == vj;
        stat.short_final = (CW'(i_reg) + CW'(1)) == seen_reg;
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = value_reg;
    assign m_saturated = sat_reg;
    assign m_too_short = short_reg;
    assign m_final_res = fin_reg;

endmodule
